// ----- hw/rtl/toeq_pkg.sv -----
// Shared types and constants for the time-ordered event queue.
package toeq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int SEQ_W = 16;
    localparam int TYPE_W = 4;
    localparam int TIME_W = 31;
    localparam int OUT_CNT_W = 5;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP = 1'b1;

    localparam logic [TYPE_W-1:0] PRELOAD_EARLY_TYPE = 4'd1;
    localparam logic [TYPE_W-1:0] PRELOAD_LATE_TYPE = 4'd8;
    localparam logic [TIME_W-1:0] PRELOAD_LATE_TIME = 31'd10000;
    localparam logic [CNT_W-1:0] PRELOAD_COUNT = CNT_W'(2);

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [TYPE_W-1:0] ev_type;
        logic [TIME_W-1:0] ev_time;
    } t_entry;

    typedef struct packed {
        logic load;
    } t_ctrl_cmd;

endpackage

// ----- hw/rtl/toeq_ctrl.sv -----
// Handshake controller that decides when a beat is taken and the result register loads.
module toeq_ctrl
    import toeq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  logic      i_stall,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_EMPTY = 2'b01,
        ST_FULL  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_stall = (r_state == ST_FULL) && i_stall;
    assign accept = i_valid && !o_stall;
    assign o_valid = (r_state == ST_FULL);
    assign o_cmd.load = accept;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_EMPTY: begin
                if (accept) begin
                    n_state = ST_FULL;
                end
            end
            ST_FULL: begin
                if (accept) begin
                    n_state = ST_FULL;
                end else if (!i_stall) begin
                    n_state = ST_EMPTY;
                end
            end
            default: n_state = ST_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/toeq_datapath.sv -----
// Sorted register chain of events with insert and pop logic and the result register.
module toeq_datapath
    import toeq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  logic              i_mode,
    input  logic [SEQ_W-1:0]  i_event_seq,
    input  logic [TYPE_W-1:0] i_event_type,
    input  logic [TIME_W-1:0] i_event_time,
    output logic [SEQ_W-1:0]  o_out_seq,
    output logic [TYPE_W-1:0] o_out_type,
    output logic [TIME_W-1:0] o_out_time,
    output logic              o_pop_valid,
    output logic              o_push_dropped,
    output logic              o_pop_on_empty,
    output logic [OUT_CNT_W-1:0] o_entry_count
);

    t_entry           r_entries [QUEUE_DEPTH];
    t_entry           n_entries [QUEUE_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [QUEUE_DEPTH-1:0] later;
    logic             full;
    logic             empty;
    logic             do_push;
    logic             do_pop;
    t_entry           new_entry;

    t_entry           r_out;
    logic             r_pop_valid;
    logic             r_push_dropped;
    logic             r_pop_on_empty;

    assign full = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty = (r_count == '0);
    assign do_push = i_cmd.load && (i_mode == MODE_PUSH) && !full;
    assign do_pop = i_cmd.load && (i_mode == MODE_POP) && !empty;
    assign new_entry = '{seq: i_event_seq, ev_type: i_event_type, ev_time: i_event_time};

    // Each held cell flags whether its time is strictly later than the new event.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            later[i] = (CNT_W'(i) < r_count) && (r_entries[i].ev_time > i_event_time);
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_entries[i] = r_entries[i];
            if (do_push) begin
                if (i > 0 && later[(i > 0) ? i - 1 : 0]) begin
                    n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                end else if (later[i] || (CNT_W'(i) == r_count)) begin
                    n_entries[i] = new_entry;
                end
            end else if (do_pop) begin
                if (i < QUEUE_DEPTH - 1) begin
                    n_entries[i] = r_entries[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries[0] <= '{seq: '0, ev_type: PRELOAD_EARLY_TYPE, ev_time: '0};
            r_entries[1] <= '{seq: '0, ev_type: PRELOAD_LATE_TYPE, ev_time: PRELOAD_LATE_TIME};
        end else begin
            r_entries <= n_entries;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= PRELOAD_COUNT;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= do_pop ? r_entries[0] : '0;
            r_pop_valid <= do_pop;
            r_push_dropped <= (i_mode == MODE_PUSH) && full;
            r_pop_on_empty <= (i_mode == MODE_POP) && empty;
        end
    end

    assign o_out_seq = r_out.seq;
    assign o_out_type = r_out.ev_type;
    assign o_out_time = r_out.ev_time;
    assign o_pop_valid = r_pop_valid;
    assign o_push_dropped = r_push_dropped;
    assign o_pop_on_empty = r_pop_on_empty;
    assign o_entry_count = OUT_CNT_W'(r_count);

endmodule

// ----- hw/rtl/time_ordered_event_queue.sv -----
// Top level of the time-ordered event queue.
// The queue holds up to QUEUE_DEPTH events sorted by time in a chain of registers, and every
// cell compares itself with a pushed event at once: a beat is taken on any cycle unless a
// result is still held and the output is stalled. The result of a beat is registered and
// appears on the output in the cycle after it is taken, and entry_count shows the number of
// events held after that beat. Reset preloads two events: time 0 of type 1 and time 10000 of
// type 8. Events with equal times leave in arrival order.
module time_ordered_event_queue
    import toeq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_mode,
    input  logic [SEQ_W-1:0]  i_event_seq,
    input  logic [TYPE_W-1:0] i_event_type,
    input  logic [TIME_W-1:0] i_event_time,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [SEQ_W-1:0]  o_out_seq,
    output logic [TYPE_W-1:0] o_out_type,
    output logic [TIME_W-1:0] o_out_time,
    output logic              o_pop_valid,
    output logic              o_push_dropped,
    output logic              o_pop_on_empty,
    output logic [OUT_CNT_W-1:0] o_entry_count
);

    t_ctrl_cmd cmd;

    toeq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    toeq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_mode         (i_mode),
        .i_event_seq    (i_event_seq),
        .i_event_type   (i_event_type),
        .i_event_time   (i_event_time),
        .o_out_seq      (o_out_seq),
        .o_out_type     (o_out_type),
        .o_out_time     (o_out_time),
        .o_pop_valid    (o_pop_valid),
        .o_push_dropped (o_push_dropped),
        .o_pop_on_empty (o_pop_on_empty),
        .o_entry_count  (o_entry_count)
    );

endmodule
